// File: rtl/dpsc_pkg.sv
// Shared types, codes and helpers for the dual-policy set-associative cache.
// No dependencies; imported by dpsc_set_update, the top level and the testbench.
`default_nettype none
package dpsc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OUT_W  = 232;

  // Access kinds carried in tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  // Outcome of one lookup in one tag store
  typedef struct packed {
    logic       hit;
    logic [1:0] refs;
  } upd_res_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/dpsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dpsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/dpsc_set_update.sv
// Hit search, victim choice and LRU refresh for one set of one tag store.
// Depends on dpsc_pkg.
`default_nettype none
module dpsc_set_update #(
  parameter int unsigned MAX_WAYS = 8,
  parameter bit          IS_WB    = 1'b0,
  parameter int unsigned RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int unsigned WW       = 2 + RW + dpsc_pkg::TAG_W
) (
  input  wire logic [MAX_WAYS*WW-1:0]       row_i,
  input  wire logic                         row_init_i,
  input  wire logic [MAX_WAYS-1:0]          way_en_i,
  input  wire logic                         cmd_i,
  input  wire logic [dpsc_pkg::TAG_W-1:0]   tag_i,
  output logic      [MAX_WAYS*WW-1:0]       row_o,
  output dpsc_pkg::upd_res_t                res_o
);
  import dpsc_pkg::*;

  logic [MAX_WAYS-1:0] vld, drt, hitv, vld_n, drt_n;
  logic [RW-1:0]       rnk   [MAX_WAYS];
  logic [RW-1:0]       rnk_n [MAX_WAYS];
  logic [TAG_W-1:0]    tg    [MAX_WAYS];
  logic [TAG_W-1:0]    tg_n  [MAX_WAYS];
  logic [RW-1:0]       hit_way, empty_way, lru_way, vic_way, tch_way, r0;
  logic                any_hit, any_empty, alloc, do_touch, is_wr;

  always_comb begin
    is_wr = (cmd_i == CMD_WRITE);
    // unpack; a row never written reads as its reset value
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (row_init_i) begin
        tg[w]  = row_i[w*WW +: TAG_W];
        rnk[w] = row_i[w*WW + TAG_W +: RW];
        drt[w] = row_i[w*WW + TAG_W + RW];
        vld[w] = row_i[w*WW + TAG_W + RW + 1];
      end else begin
        tg[w]  = '0;
        rnk[w] = RW'(w);
        drt[w] = 1'b0;
        vld[w] = 1'b0;
      end
      hitv[w] = way_en_i[w] & vld[w] & (tg[w] == tag_i);
    end

    // lowest matching way and lowest empty way
    any_hit   = |hitv;
    hit_way   = '0;
    any_empty = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) hit_way = RW'(w);
      if (way_en_i[w] && !vld[w]) begin
        any_empty = 1'b1;
        empty_way = RW'(w);
      end
    end

    // oldest enabled way, lowest wins a tie
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (way_en_i[w] && (rnk[w] > rnk[lru_way])) lru_way = RW'(w);
    end
    vic_way = any_empty ? empty_way : lru_way;

    alloc    = !any_hit && (IS_WB || !is_wr);
    do_touch = any_hit || alloc;
    tch_way  = any_hit ? hit_way : vic_way;
    r0       = rnk[tch_way];

    res_o.hit  = any_hit;
    if (IS_WB) begin
      res_o.refs = any_hit ? 2'd0 : ((vld[vic_way] && drt[vic_way]) ? 2'd2 : 2'd1);
    end else begin
      res_o.refs = any_hit ? {1'b0, is_wr} : 2'd1;
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      vld_n[w] = vld[w];
      drt_n[w] = drt[w];
      tg_n[w]  = tg[w];
      rnk_n[w] = rnk[w];
      if (do_touch) begin
        if (RW'(w) == tch_way) begin
          rnk_n[w] = '0;
        end else if (rnk[w] < r0) begin
          rnk_n[w] = rnk[w] + 1'b1;
        end
      end
      if (RW'(w) == tch_way) begin
        if (alloc) begin
          vld_n[w] = 1'b1;
          tg_n[w]  = tag_i;
          drt_n[w] = IS_WB ? is_wr : 1'b0;
        end else if (any_hit && IS_WB && is_wr) begin
          drt_n[w] = 1'b1;
        end
      end
      row_o[w*WW +: WW] = {vld_n[w], drt_n[w], rnk_n[w], tg_n[w]};
    end
  end

endmodule
`default_nettype wire

// File: rtl/dual_policy_set_assoc_cache_model.sv
// Dual-policy set-associative cache model: two LRU tag stores in RAM.
// Depends on dpsc_pkg, dpsc_ram and dpsc_set_update.
//
// Usage:
//   Input channel s_axis: tdata is the 32-bit byte address, tuser the access
//   kind (read or write). Output channel m_axis: one item per access with the
//   hit flags, memory references of this access and seven saturating totals.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (offset bits, index bits, ways in use); write only while the block idles.
// Timing:
//   An accepted item reads one row (all ways of a set) of each tag store in
//   the accept cycle; in the next cycle both rows are searched, updated and
//   written back, and the result item is loaded. No new item is taken while
//   a lookup is in progress: the read-modify-write of the set row finishes first.
// Reset:
//   Counters clear and every set reads as empty with ranks in way order; a
//   per-set flag marks rows that have been written, so no clearing pass runs.
// Stall:
//   The result waits in the output register; a new item is taken only when
//   that register is empty or being emptied in the same cycle.
`default_nettype none
module dual_policy_set_assoc_cache_model #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [4:0]   cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // address[31:0]
  input  wire logic [0:0]   s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // wt_hit, wt_access_mem_refs, wb_hit, wb_access_mem_refs[1:0], total_refs,
  // wt_hits_total, wt_misses_total, wt_mem_refs_total, wb_hits_total,
  // wb_misses_total, wb_mem_refs_total, 3 zero pad bits
  output logic [dpsc_pkg::OUT_W-1:0] m_axis_tdata
);
  import dpsc_pkg::*;

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned MAXIB = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WW    = 2 + RW + TAG_W;
  localparam int unsigned ROW_W = MAX_WAYS * WW;

  // configuration registers
  logic [4:0] off_q;
  logic [3:0] ib_q, ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= 5'd4;
      ib_q   <= 4'd6;
      ways_q <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_BITS: off_q  <= cfg_data_i;
        REG_INDEX_BITS:  ib_q   <= cfg_data_i[3:0];
        REG_WAYS_IN_USE: ways_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // geometry: clamp index bits and associativity
  logic [3:0]          ib_eff;
  logic [4:0]          nways;
  logic [MAX_WAYS-1:0] way_en;
  logic [5:0]          tag_shift;
  logic [31:0]         set_full, set_mask;
  logic [SET_W-1:0]    set_in;
  logic [TAG_W-1:0]    tag_in;

  always_comb begin
    ib_eff = (ib_q > 4'(MAXIB)) ? 4'(MAXIB) : ib_q;
    if (ways_q == 4'd0) begin
      nways = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      nways = 5'(MAX_WAYS);
    end else begin
      nways = {1'b0, ways_q};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = (5'(w) < nways);
    end
    set_mask  = (32'd1 << ib_eff) - 32'd1;
    set_full  = (s_axis_tdata >> off_q) & set_mask;
    set_in    = set_full[SET_W-1:0];
    tag_shift = {1'b0, off_q} + {2'b00, ib_eff};
    tag_in    = s_axis_tdata >> tag_shift;
  end

  // control
  state_e            state_q, state_d;
  logic              accept, out_take;
  logic              cmd_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic [MAX_SETS-1:0] row_init_q;

  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = accept ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser[0];
      tag_q <= tag_in;
      set_q <= set_in;
    end
  end

  // tag stores: one row holds every way of a set
  logic [ROW_W-1:0] wt_rdata, wb_rdata, wt_wdata, wb_wdata;
  logic             lookup;
  upd_res_t         wt_res, wb_res;

  assign lookup = (state_q == ST_LOOKUP);

  dpsc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_wt_ram (
    .clk_i, .we_i(lookup), .waddr_i(set_q), .wdata_i(wt_wdata),
    .re_i(accept), .raddr_i(set_in), .rdata_o(wt_rdata)
  );

  dpsc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_wb_ram (
    .clk_i, .we_i(lookup), .waddr_i(set_q), .wdata_i(wb_wdata),
    .re_i(accept), .raddr_i(set_in), .rdata_o(wb_rdata)
  );

  dpsc_set_update #(.MAX_WAYS(MAX_WAYS), .IS_WB(1'b0)) u_wt_upd (
    .row_i(wt_rdata), .row_init_i(row_init_q[set_q]), .way_en_i(way_en),
    .cmd_i(cmd_q), .tag_i(tag_q), .row_o(wt_wdata), .res_o(wt_res)
  );

  dpsc_set_update #(.MAX_WAYS(MAX_WAYS), .IS_WB(1'b1)) u_wb_upd (
    .row_i(wb_rdata), .row_init_i(row_init_q[set_q]), .way_en_i(way_en),
    .cmd_i(cmd_q), .tag_i(tag_q), .row_o(wb_wdata), .res_o(wb_res)
  );

  // totals and output register
  logic [CNT_W-1:0] tot_q, wth_q, wtm_q, wtr_q, wbh_q, wbm_q, wbr_q;
  logic             wt_hit_q, wt_ref_q, wb_hit_q;
  logic [1:0]       wb_ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      row_init_q    <= '0;
      tot_q <= '0; wth_q <= '0; wtm_q <= '0; wtr_q <= '0;
      wbh_q <= '0; wbm_q <= '0; wbr_q <= '0;
    end else begin
      state_q <= state_d;
      if (lookup) begin
        m_axis_tvalid     <= 1'b1;
        row_init_q[set_q] <= 1'b1;
        tot_q <= sat_add(tot_q, 2'd1);
        wth_q <= sat_add(wth_q, {1'b0, wt_res.hit});
        wtm_q <= sat_add(wtm_q, {1'b0, !wt_res.hit});
        wtr_q <= sat_add(wtr_q, wt_res.refs);
        wbh_q <= sat_add(wbh_q, {1'b0, wb_res.hit});
        wbm_q <= sat_add(wbm_q, {1'b0, !wb_res.hit});
        wbr_q <= sat_add(wbr_q, wb_res.refs);
      end else if (out_take) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup) begin
      wt_hit_q <= wt_res.hit;
      wt_ref_q <= wt_res.refs[0];
      wb_hit_q <= wb_res.hit;
      wb_ref_q <= wb_res.refs;
    end
  end

  assign m_axis_tdata = {3'b000, wbr_q, wbm_q, wbh_q, wtr_q, wtm_q, wth_q, tot_q,
                         wb_ref_q, wb_hit_q, wt_ref_q, wt_hit_q};

  // checks
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOKUP) else $error("accepted item not looked up");
  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup |=> m_axis_tvalid) else $error("lookup produced no result");
  a_wb_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup |-> wb_res.refs != 2'd3) else $error("write-back refs out of range");
  a_wt_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup |-> !wt_res.refs[1]) else $error("write-through refs out of range");

endmodule
`default_nettype wire

// File: tb/sv/dpsc_cache_checker.sv
// Checker for the dual-policy cache: watches configuration writes and both
// stream channels, predicts every result item and compares it field by field.
// Depends on dpsc_pkg for register indexes and access kinds.
`timescale 1ns / 1ps
module dpsc_cache_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [4:0]   cfg_data_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [dpsc_pkg::OUT_W-1:0] m_axis_tdata,
  output int                fails_o,
  output int                pending_o
);
  import dpsc_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;

  typedef struct packed {
    logic [31:0] wb_refs_tot;
    logic [31:0] wb_miss_tot;
    logic [31:0] wb_hit_tot;
    logic [31:0] wt_refs_tot;
    logic [31:0] wt_miss_tot;
    logic [31:0] wt_hit_tot;
    logic [31:0] accesses;
    logic [1:0]  wb_refs;
    logic        wb_hit;
    logic        wt_refs;
    logic        wt_hit;
  } cache_res_t;

  logic [4:0] off_bits;
  logic [3:0] idx_bits, ways_cfg;

  bit          wt_vld  [NSETS*NWAYS];
  logic [63:0] wt_tags [NSETS*NWAYS];
  bit [2:0]    wt_rank [NSETS*NWAYS];
  bit          wb_vld  [NSETS*NWAYS];
  bit          wb_drt  [NSETS*NWAYS];
  logic [63:0] wb_tags [NSETS*NWAYS];
  bit [2:0]    wb_rank [NSETS*NWAYS];
  logic [31:0] tot_acc, wt_hits, wt_miss, wt_refs, wb_hits, wb_miss, wb_refs;

  cache_res_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [31:0] sat_inc(logic [31:0] a, int unsigned b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Make way the most recent one of its set in the given rank store
  function automatic void promote(ref bit [2:0] rk[NSETS*NWAYS], input int base,
                                  input int way);
    bit [2:0] r;
    r = rk[base+way];
    for (int w = 0; w < NWAYS; w++)
      if (rk[base+w] < r) rk[base+w]++;
    rk[base+way] = 3'd0;
  endfunction

  // Lowest empty way first, else the least recently used one
  function automatic int victim(ref bit vl[NSETS*NWAYS], ref bit [2:0] rk[NSETS*NWAYS],
                                input int base, input int nw);
    int best;
    best = 0;
    for (int w = 0; w < nw; w++)
      if (!vl[base+w]) return w;
    for (int w = 1; w < nw; w++)
      if (rk[base+w] > rk[base+best]) best = w;
    return best;
  endfunction

  function automatic cache_res_t predict_access(logic cmd, logic [31:0] addr);
    cache_res_t  res;
    int          ib, nw, set, base, hw;
    logic [63:0] a64, tg;
    int unsigned v;
    a64 = {32'd0, addr};
    ib  = (idx_bits > 8) ? 8 : idx_bits;
    nw  = (ways_cfg < 1) ? 1 : (ways_cfg > NWAYS) ? NWAYS : ways_cfg;
    set = int'((a64 >> off_bits) & ((64'd1 << ib) - 1));
    tg  = a64 >> (off_bits + ib);
    base = set * NWAYS;
    res = '0;

    hw = -1;
    for (int w = 0; w < nw; w++)
      if (hw < 0 && wt_vld[base+w] && wt_tags[base+w] == tg) hw = w;
    if (hw >= 0) begin
      res.wt_hit  = 1'b1;
      res.wt_refs = (cmd == CMD_WRITE);
      promote(wt_rank, base, hw);
    end else begin
      res.wt_refs = 1'b1;
      if (cmd == CMD_READ) begin
        v = victim(wt_vld, wt_rank, base, nw);
        wt_vld[base+v]  = 1'b1;
        wt_tags[base+v] = tg;
        promote(wt_rank, base, v);
      end
    end

    hw = -1;
    for (int w = 0; w < nw; w++)
      if (hw < 0 && wb_vld[base+w] && wb_tags[base+w] == tg) hw = w;
    if (hw >= 0) begin
      res.wb_hit = 1'b1;
      if (cmd == CMD_WRITE) wb_drt[base+hw] = 1'b1;
      promote(wb_rank, base, hw);
    end else begin
      v = victim(wb_vld, wb_rank, base, nw);
      res.wb_refs = (wb_vld[base+v] && wb_drt[base+v]) ? 2'd2 : 2'd1;
      wb_vld[base+v]  = 1'b1;
      wb_tags[base+v] = tg;
      wb_drt[base+v]  = (cmd == CMD_WRITE);
      promote(wb_rank, base, v);
    end

    tot_acc = sat_inc(tot_acc, 1);
    wt_hits = sat_inc(wt_hits, res.wt_hit);
    wt_miss = sat_inc(wt_miss, !res.wt_hit);
    wt_refs = sat_inc(wt_refs, res.wt_refs);
    wb_hits = sat_inc(wb_hits, res.wb_hit);
    wb_miss = sat_inc(wb_miss, !res.wb_hit);
    wb_refs = sat_inc(wb_refs, res.wb_refs);
    res.accesses    = tot_acc;
    res.wt_hit_tot  = wt_hits;
    res.wt_miss_tot = wt_miss;
    res.wt_refs_tot = wt_refs;
    res.wb_hit_tot  = wb_hits;
    res.wb_miss_tot = wb_miss;
    res.wb_refs_tot = wb_refs;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cache_res_t e, a;
    if (!rst_ni) begin
      off_bits = 5'd4;
      idx_bits = 4'd6;
      ways_cfg = 4'd4;
      for (int i = 0; i < NSETS*NWAYS; i++) begin
        wt_vld[i]  = 1'b0;
        wb_vld[i]  = 1'b0;
        wb_drt[i]  = 1'b0;
        wt_tags[i] = '0;
        wb_tags[i] = '0;
        wt_rank[i] = 3'(i % NWAYS);
        wb_rank[i] = 3'(i % NWAYS);
      end
      {tot_acc, wt_hits, wt_miss, wt_refs, wb_hits, wb_miss, wb_refs} = '0;
      expected_results.delete();
      fails_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFSET_BITS: off_bits = cfg_data_i;
          REG_INDEX_BITS:  idx_bits = cfg_data_i[3:0];
          REG_WAYS_IN_USE: ways_cfg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_access(s_axis_tuser[0], s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        a = cache_res_t'(m_axis_tdata[$bits(cache_res_t)-1:0]);
        if (expected_results.size() == 0) begin
          $error("result item with no access outstanding");
          fails_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("wt_hit", e.wt_hit, a.wt_hit);
          check_field("wt_access_mem_refs", e.wt_refs, a.wt_refs);
          check_field("wb_hit", e.wb_hit, a.wb_hit);
          check_field("wb_access_mem_refs", e.wb_refs, a.wb_refs);
          check_field("total_refs", e.accesses, a.accesses);
          check_field("wt_hits_total", e.wt_hit_tot, a.wt_hit_tot);
          check_field("wt_misses_total", e.wt_miss_tot, a.wt_miss_tot);
          check_field("wt_mem_refs_total", e.wt_refs_tot, a.wt_refs_tot);
          check_field("wb_hits_total", e.wb_hit_tot, a.wb_hit_tot);
          check_field("wb_misses_total", e.wb_miss_tot, a.wb_miss_tot);
          check_field("wb_mem_refs_total", e.wb_refs_tot, a.wb_refs_tot);
        end
      end
    end
  end

endmodule

// File: tb/sv/dual_policy_set_assoc_cache_model_test.sv
// Top of the dual-policy cache testbench: clock, reset, access stimulus,
// result back-pressure and verdict. Depends on dpsc_pkg, the block and
// dpsc_cache_checker, which does all prediction and comparison.
`timescale 1ns / 1ps
module dual_policy_set_assoc_cache_model_test;
  import dpsc_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // address[31:0]
  logic [0:0]  s_axis_tuser;   // command
  logic        m_axis_tvalid, m_axis_tready;
  // wt_hit, wt_access_mem_refs, wb_hit, wb_access_mem_refs[1:0], seven totals, pad
  logic [OUT_W-1:0] m_axis_tdata;

  int fails, pending;
  bit idling_on;     // cleared for the last phase so both sides run flat out
  bit item_taken;    // registered handshake, read by the sender at the falling edge
  int accesses_sent;
  int cfg_phases;

  dual_policy_set_assoc_cache_model dut (.*);

  dpsc_cache_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fails_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) item_taken <= s_axis_tvalid && s_axis_tready;

  // Receiver: stall in random bursts, with long free-running stretches
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one access; hold it until taken, sometimes after an idle burst
  task automatic send_access(logic cmd, logic [31:0] addr);
    if (idling_on && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = addr;
    s_axis_tuser  = cmd;
    do @(negedge clk_i); while (!item_taken);
    s_axis_tvalid = 1'b0;
    accesses_sent++;
  endtask

  task automatic drain;
    while (pending != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_geometry(logic [4:0] offs, logic [4:0] idxb, logic [4:0] ways);
    drain();
    write_reg(REG_OFFSET_BITS, offs);
    write_reg(REG_INDEX_BITS, idxb);
    write_reg(REG_WAYS_IN_USE, ways);
    cfg_phases++;
  endtask

  // Mostly a small pool of nearby lines so hits, evictions and dirty
  // write-backs all occur; some fully random addresses toggle every bit.
  task automatic random_phase(int count);
    logic [31:0] line_pool[8];
    logic [31:0] addr;
    foreach (line_pool[i]) line_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) addr = $urandom();
      else addr = line_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
      send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, addr);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_READ;
    idling_on = 1'b1;
    accesses_sent = 0;
    cfg_phases = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset geometry: 16-byte lines, 64 sets, 4 ways; set 0 addresses step by 1024
    for (int t = 0; t < 5; t++) send_access(CMD_READ, 32'(t << 10));   // fill, then evict
    send_access(CMD_WRITE, 32'h0000_0400);   // hit both, wb line goes dirty
    send_access(CMD_WRITE, 32'h0000_1400);   // wt miss without allocation
    send_access(CMD_READ, 32'h0000_0000);    // misses both, evicts a clean line in wb
    send_access(CMD_READ, 32'h0000_0800);
    send_access(CMD_READ, 32'h0000_0c0f);    // line of 0x0c00, other offset
    send_access(CMD_READ, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_READ, 32'h1000_1400);
    // Hold the sender until every result is back
    drain();

    random_phase(70);
    set_geometry(5'd0, 5'd0, 5'd1);     // byte lines, one set, direct mapped
    random_phase(60);
    set_geometry(5'd31, 5'd15, 5'd0);   // huge offset, index saturates, ways 0 acts as 1
    random_phase(40);
    set_geometry(5'd16, 5'd8, 5'd8);    // full geometry
    random_phase(70);
    set_geometry(5'd5, 5'd3, 5'd15);    // ways clamp to the maximum
    random_phase(70);
    set_geometry(5'd2, 5'd7, 5'd2);     // shrink ways without a flush
    random_phase(70);
    set_geometry(5'($urandom_range(0, 16)), 5'($urandom_range(0, 8)),
                 5'($urandom_range(1, 8)));
    idling_on = 1'b0;
    random_phase(110);

    drain();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d accesses over %0d geometry settings, including clamped",
             accesses_sent, cfg_phases + 1);
    $display("index and way counts, dirty evictions and write-through misses.");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

endmodule
